// ===== src/reversible_deque_trim_assert.svh =====
// ----------------------------------------------------------------------------
// reversible_deque_trim assertion macros
// Concurrent assertion helpers that compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef REVERSIBLE_DEQUE_TRIM_ASSERT_SVH
`define REVERSIBLE_DEQUE_TRIM_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define RDT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rdt assertion failed");
// next-cycle implication
`define RDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rdt assertion failed");
`else
`define RDT_ASSERT_NOW(label, clk, rst, ante, cons)
`define RDT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/rdt_pkg.sv =====
// ----------------------------------------------------------------------------
// rdt_pkg
// Shared types and command codes of the reversible deque trim block.
// ----------------------------------------------------------------------------
package rdt_pkg;

   localparam int FUNC_W  = 3;
   localparam int VALUE_W = 16;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_APPEND  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_REVERSE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DELETE  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_EMIT  = 3'b100
   } rdt_state_type;

   // controller to datapath
   typedef struct packed {
      logic exec;     // apply accepted command
      logic load;     // set up a read-out run
      logic fetch;    // read first element
      logic advance;  // step to next element and read it
   } rdt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic read_cmd; // incoming command is read-out
      logic marker;   // read-out gives a single error or empty result
      logic last;     // current result ends the run
   } rdt_status_type;

endpackage

// ===== src/rdt_req_if.sv =====
// ----------------------------------------------------------------------------
// rdt_req_if
// Command channel: function code and value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rdt_req_if import rdt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [VALUE_W-1:0] value;

   modport source (output valid, func, value, input ready);
   modport sink   (input valid, func, value, output ready);
endinterface

// ===== src/rdt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rdt_rsp_if
// Result channel: element, error and empty markers, end of run flag.
// ----------------------------------------------------------------------------
interface rdt_rsp_if import rdt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] item;
   logic               error;
   logic               empty_res;
   logic               last;

   modport source (output valid, item, error, empty_res, last, input ready);
   modport sink   (input valid, item, error, empty_res, last, output ready);
endinterface

// ===== src/reversible_deque_trim.sv =====
// ----------------------------------------------------------------------------
// reversible_deque_trim
// List store with lazy reversal: clear, append, reverse, delete head and
// read-out commands over a valid/ready command and result channel.
// ----------------------------------------------------------------------------
// Clear, append, reverse, delete and unused codes are applied on acceptance and
// produce no result. A read-out of N elements is accepted in ST_IDLE, then
// ST_FETCH reads the first element, because the element RAM has a registered
// read port. After that it delivers one element per cycle while the sink keeps
// ready high. The next command can be taken in the cycle after the last
// transaction. An error or empty read-out gives its one result in the cycle
// after acceptance. No new command is taken until the last result of a
// read-out has been delivered.
`include "reversible_deque_trim_assert.svh"

module reversible_deque_trim import rdt_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int VALUE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   rdt_req_if.sink    req_chan,
   rdt_rsp_if.source  rsp_chan
);

   rdt_cmd_type    cmd;
   rdt_status_type status;

   rdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rdt_dp #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_func      (req_chan.func),
      .req_value     (req_chan.value),
      .cmd           (cmd),
      .status        (status),
      .rsp_item      (rsp_chan.item),
      .rsp_error     (rsp_chan.error),
      .rsp_empty_res (rsp_chan.empty_res),
      .rsp_last      (rsp_chan.last)
   );

   `RDT_ASSERT_NOW(a_marker_last, clock, reset,
                   rsp_chan.valid && (rsp_chan.error || rsp_chan.empty_res), rsp_chan.last)
   `RDT_ASSERT_NOW(a_one_at_a_time, clock, reset, req_chan.ready, !rsp_chan.valid)

endmodule

// ===== src/rdt_ram.sv =====
// ----------------------------------------------------------------------------
// rdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rdt_ram #(
   parameter int WIDTH     = 16,
   parameter int DEPTH     = 64,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== src/rdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// rdt_ctrl
// Sequencer: takes one command, then runs the read-out stream if asked.
// ----------------------------------------------------------------------------
module rdt_ctrl import rdt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  rdt_status_type status,
   output rdt_cmd_type    cmd
);

   rdt_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               if (status.read_cmd) begin
                  cmd.load = 1'b1;
                  state_in = status.marker ? ST_EMIT : ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  // read the next element while this transaction completes
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/rdt_dp.sv =====
// ----------------------------------------------------------------------------
// rdt_dp
// Datapath: front/back indices, direction and error flags, element RAM,
// read-out cursor and result fields.
// ----------------------------------------------------------------------------
`include "reversible_deque_trim_assert.svh"

module rdt_dp import rdt_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int VALUE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [VALUE_W-1:0] req_value,
   input  rdt_cmd_type        cmd,
   output rdt_status_type     status,
   output logic [VALUE_W-1:0] rsp_item,
   output logic               rsp_error,
   output logic               rsp_empty_res,
   output logic               rsp_last
);

   localparam int IDX_BITS   = $clog2(DEPTH + 1);
   localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int STORE_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

   logic [IDX_BITS-1:0]   front_ff, front_in;
   logic [IDX_BITS-1:0]   back_ff, back_in;
   logic                  reversed_ff, reversed_in;
   logic                  error_ff, error_in;
   logic [ADDR_BITS-1:0]  ptr_ff, ptr_in;
   logic [IDX_BITS-1:0]   rem_ff, rem_in;
   logic                  err_mark_ff, err_mark_in;
   logic                  empty_mark_ff, empty_mark_in;

   logic                  list_empty;
   logic                  list_full;
   logic [IDX_BITS-1:0]   back_dec;
   logic [ADDR_BITS-1:0]  ptr_step;
   logic                  wr_en;
   logic                  rd_en;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [STORE_BITS-1:0] rd_data_ff;

   assign list_empty = (front_ff >= back_ff);
   assign list_full  = (back_ff == IDX_BITS'(DEPTH));
   assign back_dec   = back_ff - 1'b1;
   assign ptr_step   = reversed_ff ? (ptr_ff - 1'b1) : (ptr_ff + 1'b1);

   always_comb begin
      front_in    = front_ff;
      back_in     = back_ff;
      reversed_in = reversed_ff;
      error_in    = error_ff;
      wr_en       = 1'b0;
      if (cmd.exec) begin
         case (req_func)
            FUNC_CLEAR: begin
               front_in    = '0;
               back_in     = '0;
               reversed_in = 1'b0;
               error_in    = 1'b0;
            end
            FUNC_APPEND: begin
               // drop the value when full
               if (list_full) begin
                  error_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  back_in = back_ff + 1'b1;
               end
            end
            FUNC_REVERSE: begin
               reversed_in = ~reversed_ff;
            end
            FUNC_DELETE: begin
               if (list_empty) begin
                  error_in = 1'b1;
               end else if (reversed_ff) begin
                  back_in = back_dec;
               end else begin
                  front_in = front_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      ptr_in        = ptr_ff;
      rem_in        = rem_ff;
      err_mark_in   = err_mark_ff;
      empty_mark_in = empty_mark_ff;
      if (cmd.load) begin
         ptr_in        = reversed_ff ? back_dec[ADDR_BITS-1:0] : front_ff[ADDR_BITS-1:0];
         rem_in        = back_ff - front_ff;
         err_mark_in   = error_ff;
         empty_mark_in = ~error_ff & list_empty;
      end else if (cmd.advance) begin
         ptr_in = ptr_step;
         rem_in = rem_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff    <= '0;
         back_ff     <= '0;
         reversed_ff <= 1'b0;
         error_ff    <= 1'b0;
      end else begin
         front_ff    <= front_in;
         back_ff     <= back_in;
         reversed_ff <= reversed_in;
         error_ff    <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      rem_ff        <= rem_in;
      err_mark_ff   <= err_mark_in;
      empty_mark_ff <= empty_mark_in;
   end

   assign rd_en   = cmd.fetch | cmd.advance;
   assign rd_addr = cmd.advance ? ptr_step : ptr_ff;

   rdt_ram #(
      .WIDTH (STORE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (back_ff[ADDR_BITS-1:0]),
      .wr_data    (req_value[STORE_BITS-1:0]),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data_ff)
   );

   assign status.read_cmd = (req_func == FUNC_READ);
   assign status.marker   = error_ff | list_empty;
   assign status.last     = err_mark_ff | empty_mark_ff | (rem_ff == IDX_BITS'(1));

   assign rsp_item      = (err_mark_ff | empty_mark_ff) ? '0 : VALUE_W'(rd_data_ff);
   assign rsp_error     = err_mark_ff;
   assign rsp_empty_res = empty_mark_ff;
   assign rsp_last      = status.last;

   `RDT_ASSERT_NOW(a_index_order, clock, reset, 1'b1, front_ff <= back_ff)
   `RDT_ASSERT_NOW(a_back_bound, clock, reset, 1'b1, back_ff <= IDX_BITS'(DEPTH))
   `RDT_ASSERT_NEXT(a_run_length, clock, reset, cmd.load && !status.marker,
                    rem_ff != '0)

endmodule
